FILE: src/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg - shared types and constants of the frame channel sorter
// Word field positions, kind codes, cell control and result types, decoder.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int WORD_W = 64;
  localparam int KEY_W  = 6;
  localparam int TAG_W  = 5;

  localparam logic [TAG_W-1:0] TAG_EVENT     = 5'h00;
  localparam logic [TAG_W-1:0] TAG_HEARTBEAT = 5'h04;
  localparam logic [TAG_W-1:0] TAG_COUNTER   = 5'h08;

  localparam logic [1:0] KIND_EVENT     = 2'd0;
  localparam logic [1:0] KIND_HEARTBEAT = 2'd1;
  localparam logic [1:0] KIND_COUNTER   = 2'd2;
  localparam logic [1:0] KIND_OTHER     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_HBEAT,
    ST_FINISH
  } fcs_state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } fcs_op_t;

  typedef struct packed {
    fcs_op_t           op;
    logic [WORD_W-1:0] word;
  } fcs_cell_ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        kind;
    logic [2:0]        chip_id;
    logic [5:0]        channel_id;
    logic [1:0]        tac_id;
    logic [15:0]       t_coarse;
    logic [9:0]        e_coarse;
    logic [9:0]        t_fine;
    logic [9:0]        e_fine;
    logic [15:0]       frame_count;
    logic              last_of_run;
    logic              overflow;
  } fcs_result_t;

  function automatic logic [KEY_W-1:0] key_of(input logic [WORD_W-1:0] w);
    key_of = w[53:48];
  endfunction

  function automatic logic is_heartbeat(input logic [WORD_W-1:0] w);
    is_heartbeat = (w[63:59] == TAG_HEARTBEAT);
  endfunction

  function automatic fcs_result_t decode(input logic [WORD_W-1:0] w, input logic ovf,
                                         input logic last);
    fcs_result_t r;
    r             = '0;
    r.word        = w;
    r.chip_id     = w[58:56];
    r.overflow    = ovf;
    r.last_of_run = last;
    case (w[63:59])
      TAG_EVENT: begin
        r.kind       = KIND_EVENT;
        r.channel_id = w[53:48];
        r.tac_id     = w[47:46];
        r.t_coarse   = w[45:30];
        r.e_coarse   = w[29:20];
        r.t_fine     = w[19:10];
        r.e_fine     = w[9:0];
      end
      TAG_HEARTBEAT: begin
        r.kind        = KIND_HEARTBEAT;
        r.frame_count = w[30:15];
      end
      TAG_COUNTER: begin
        r.kind       = KIND_COUNTER;
        r.channel_id = w[29:24];
      end
      default: begin
        r.kind = KIND_OTHER;
      end
    endcase
    decode = r;
  endfunction

endpackage

FILE: src/fcs_cell.sv
// ----------------------------------------------------------------------------
// fcs_cell - one slot of the sorted frame chain
// Holds one word; on insert keeps it, takes the left neighbour's word or the
// new item; on shift takes the right neighbour's word.
// ----------------------------------------------------------------------------
module fcs_cell (
  input  logic                        clk,
  input  fcs_pkg::fcs_cell_ctrl_t     ctrl_i,
  input  logic                        occ_i,
  input  logic                        left_gt_i,
  input  logic [fcs_pkg::WORD_W-1:0]  left_word_i,
  input  logic [fcs_pkg::WORD_W-1:0]  right_word_i,
  output logic [fcs_pkg::WORD_W-1:0]  word_o,
  output logic                        gt_o
);

  logic [fcs_pkg::WORD_W-1:0] word_r;
  logic [fcs_pkg::WORD_W-1:0] word_nxt;

  assign gt_o   = occ_i && (fcs_pkg::key_of(word_r) > fcs_pkg::key_of(ctrl_i.word));
  assign word_o = word_r;

  always_comb begin
    word_nxt = word_r;
    case (ctrl_i.op)
      fcs_pkg::OP_INSERT: begin
        if (left_gt_i) begin
          word_nxt = left_word_i;
        end else if (gt_o || !occ_i) begin
          word_nxt = ctrl_i.word;
        end
      end
      fcs_pkg::OP_SHIFT: begin
        word_nxt = right_word_i;
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

FILE: src/fcs_chain.sv
// ----------------------------------------------------------------------------
// fcs_chain - row of sort cells
// Keeps the buffered words sorted by channel key; head cell feeds the flush.
// ----------------------------------------------------------------------------
module fcs_chain #(
  parameter int DEPTH  = 32,
  parameter int FILL_W = 6
) (
  input  logic                        clk,
  input  fcs_pkg::fcs_cell_ctrl_t     ctrl_i,
  input  logic [FILL_W-1:0]           fill_i,
  output logic [fcs_pkg::WORD_W-1:0]  head_word_o
);

  logic [fcs_pkg::WORD_W-1:0] cell_word [DEPTH];
  logic                       cell_gt   [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                       occ;
      logic                       left_gt;
      logic [fcs_pkg::WORD_W-1:0] left_word;
      logic [fcs_pkg::WORD_W-1:0] right_word;

      assign occ = (FILL_W'(i) < fill_i);

      if (i == 0) begin : g_first
        assign left_gt   = 1'b0;
        assign left_word = '0;
      end else begin : g_mid
        assign left_gt   = cell_gt[i-1];
        assign left_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_word = cell_word[i];
      end else begin : g_inner
        assign right_word = cell_word[i+1];
      end

      fcs_cell u_cell (
        .clk          (clk),
        .ctrl_i       (ctrl_i),
        .occ_i        (occ),
        .left_gt_i    (left_gt),
        .left_word_i  (left_word),
        .right_word_i (right_word),
        .word_o       (cell_word[i]),
        .gt_o         (cell_gt[i])
      );
    end
  endgenerate

  assign head_word_o = cell_word[0];

endmodule

FILE: src/frame_channel_sorter.sv
// ----------------------------------------------------------------------------
// frame_channel_sorter - frame buffer that sorts readout words by channel
// Buffers non-heartbeat words in a sorted cell chain, drains it on a
// heartbeat or end of stream, drops repeats of the last emitted word and
// decodes each result by kind.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  data_word, end_of_stream
//   out_     output     out_valid/out_ready decoded word, last_of_run, overflow
//
// A buffered word is taken in the idle state, so such items enter every
// cycle while no drain runs. A drain holds the input after a heartbeat or
// end of stream: it pops each buffered word from the head cell, sees the
// chain empty, passes the heartbeat (after a heartbeat only) and then
// releases the held last result.
// Each result waits in a holding register until the next one is known, so
// last_of_run is exact; out_ready low holds the drain.
// Reset (rst_n low, synchronous) empties the buffer and clears the flags.
// ----------------------------------------------------------------------------
module frame_channel_sorter #(
  parameter int FRAME_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_word,
  output logic [1:0]  out_word_kind,
  output logic [2:0]  out_chip_id,
  output logic [5:0]  out_channel_id,
  output logic [1:0]  out_tac_id,
  output logic [15:0] out_t_coarse,
  output logic [9:0]  out_e_coarse,
  output logic [9:0]  out_t_fine,
  output logic [9:0]  out_e_fine,
  output logic [15:0] out_frame_count,
  output logic        out_last_of_run,
  output logic        out_overflow
);

  localparam int FILL_W = $clog2(FRAME_DEPTH + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(FRAME_DEPTH);

  fcs_pkg::fcs_state_t        state_r, state_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [63:0]                prev_r, prev_nxt;
  logic                       dropped_r, dropped_nxt;
  logic [63:0]                hb_r, hb_nxt;
  logic                       hb_pend_r, hb_pend_nxt;
  logic                       cand_valid_r, cand_valid_nxt;
  logic [63:0]                cand_word_r, cand_word_nxt;
  logic                       cand_ovf_r, cand_ovf_nxt;
  logic                       out_valid_r, out_valid_nxt;
  fcs_pkg::fcs_result_t       out_r, out_nxt;

  fcs_pkg::fcs_cell_ctrl_t    ctrl;
  logic [63:0]                head_word;
  logic                       accept;
  logic                       in_hb;
  logic                       out_free;
  logic                       advance;
  logic                       src_valid;
  logic [63:0]                src_word;
  logic                       emit_new;

  assign in_ready = (state_r == fcs_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_hb    = fcs_pkg::is_heartbeat(in_data_word);
  assign out_free = !out_valid_r || out_ready;
  assign advance  = !cand_valid_r || out_free;

  fcs_chain #(
    .DEPTH  (FRAME_DEPTH),
    .FILL_W (FILL_W)
  ) u_chain (
    .clk         (clk),
    .ctrl_i      (ctrl),
    .fill_i      (fill_r),
    .head_word_o (head_word)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcs_pkg::ST_IDLE: begin
        if (accept && (in_hb || in_end_of_stream)) begin
          state_nxt = fcs_pkg::ST_FLUSH;
        end
      end
      fcs_pkg::ST_FLUSH: begin
        if (fill_r == '0) begin
          state_nxt = hb_pend_r ? fcs_pkg::ST_HBEAT : fcs_pkg::ST_FINISH;
        end
      end
      fcs_pkg::ST_HBEAT: begin
        if (advance) begin
          state_nxt = fcs_pkg::ST_FINISH;
        end
      end
      fcs_pkg::ST_FINISH: begin
        if (!cand_valid_r || out_free) begin
          state_nxt = fcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.op        = fcs_pkg::OP_HOLD;
    ctrl.word      = in_data_word;
    fill_nxt       = fill_r;
    dropped_nxt    = dropped_r;
    hb_nxt         = hb_r;
    hb_pend_nxt    = hb_pend_r;
    src_valid      = 1'b0;
    src_word       = head_word;
    prev_nxt       = prev_r;
    cand_valid_nxt = cand_valid_r;
    cand_word_nxt  = cand_word_r;
    cand_ovf_nxt   = cand_ovf_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    case (state_r)
      fcs_pkg::ST_IDLE: begin
        if (accept) begin
          hb_nxt      = in_data_word;
          hb_pend_nxt = in_hb;
          if (!in_hb) begin
            if (fill_r < FULL) begin
              ctrl.op  = fcs_pkg::OP_INSERT;
              fill_nxt = fill_r + 1'b1;
            end else begin
              dropped_nxt = 1'b1;
            end
          end
        end
      end
      fcs_pkg::ST_FLUSH: begin
        if (fill_r != '0 && advance) begin
          ctrl.op   = fcs_pkg::OP_SHIFT;
          fill_nxt  = fill_r - 1'b1;
          src_valid = 1'b1;
        end
      end
      fcs_pkg::ST_HBEAT: begin
        src_word  = hb_r;
        src_valid = advance;
      end
      fcs_pkg::ST_FINISH: begin
        dropped_nxt = 1'b0;
        if (cand_valid_r && out_free) begin
          out_nxt        = fcs_pkg::decode(cand_word_r, cand_ovf_r, 1'b1);
          out_valid_nxt  = 1'b1;
          cand_valid_nxt = 1'b0;
        end
      end
      default: begin
        ctrl.op = fcs_pkg::OP_HOLD;
      end
    endcase

    emit_new = src_valid && (src_word != prev_r);
    if (emit_new) begin
      prev_nxt = src_word;
      if (cand_valid_r) begin
        out_nxt       = fcs_pkg::decode(cand_word_r, cand_ovf_r, 1'b0);
        out_valid_nxt = 1'b1;
      end
      cand_valid_nxt = 1'b1;
      cand_word_nxt  = src_word;
      cand_ovf_nxt   = dropped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fcs_pkg::ST_IDLE;
      fill_r       <= '0;
      prev_r       <= '0;
      dropped_r    <= 1'b0;
      hb_pend_r    <= 1'b0;
      cand_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      prev_r       <= prev_nxt;
      dropped_r    <= dropped_nxt;
      hb_pend_r    <= hb_pend_nxt;
      cand_valid_r <= cand_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hb_r        <= hb_nxt;
    cand_word_r <= cand_word_nxt;
    cand_ovf_r  <= cand_ovf_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_word        = out_r.word;
  assign out_word_kind   = out_r.kind;
  assign out_chip_id     = out_r.chip_id;
  assign out_channel_id  = out_r.channel_id;
  assign out_tac_id      = out_r.tac_id;
  assign out_t_coarse    = out_r.t_coarse;
  assign out_e_coarse    = out_r.e_coarse;
  assign out_t_fine      = out_r.t_fine;
  assign out_e_fine      = out_r.e_fine;
  assign out_frame_count = out_r.frame_count;
  assign out_last_of_run = out_r.last_of_run;
  assign out_overflow    = out_r.overflow;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count beyond frame depth");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_hb && fill_r == FULL) |=> dropped_r)
    else $error("word dropped without flag");

  a_idle_no_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcs_pkg::ST_IDLE) |-> !cand_valid_r)
    else $error("held result left behind after drain");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcs_pkg::ST_FLUSH && fill_r != '0 && advance)
      |=> fill_r == $past(fill_r) - 1'b1)
    else $error("drain pop lost");

endmodule
